FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros. They are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TUN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be seen at a clock edge outside reset.
`define TUN_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define TUN_ASSERT(label, clk, rst_n, prop)
`define TUN_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hdl/tun_pkg.sv
// ----------------------------------------------------------------------------
// Triangle normal package
// Widths, latencies and beat types shared by the triangle normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

    // Input and edge widths.
    localparam int COORD_WIDTH  = 16;
    localparam int EDGE_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * EDGE_WIDTH;
    localparam int CROSS_WIDTH  = PROD_WIDTH + 1;
    localparam int MAG_WIDTH    = CROSS_WIDTH - 1;
    localparam int SQR_WIDTH    = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH    = SQR_WIDTH + 2;
    localparam int ROOT_WIDTH   = SUM_WIDTH / 2;

    // Result widths.
    localparam int NORM_WIDTH   = 16;
    localparam int AREA_WIDTH   = 36;
    localparam int NORM_MAX     = (1 << (NORM_WIDTH - 1)) - 1;

    // Normal path: quotient of c^2 * 2^32 by the sum of squares, then its root.
    localparam int QUO_WIDTH    = 2 * NORM_WIDTH + 1;
    localparam int NROOT_WIDTH  = (QUO_WIDTH + 1) / 2;

    // Pipeline depths.
    localparam int AXES         = 3;
    localparam int FRONT_STAGES = 4;
    localparam int NORM_LAT     = QUO_WIDTH + NROOT_WIDTH;
    localparam int AREA_DLY     = NORM_LAT - ROOT_WIDTH;
    localparam int PIPE_STAGES  = FRONT_STAGES + NORM_LAT + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [NORM_WIDTH-1:0]  t_norm;

    typedef struct packed {
        t_coord first_x;
        t_coord first_y;
        t_coord first_z;
        t_coord second_x;
        t_coord second_y;
        t_coord second_z;
        t_coord third_x;
        t_coord third_y;
        t_coord third_z;
    } t_tri_in;

    typedef struct packed {
        t_norm                  normal_x;
        t_norm                  normal_y;
        t_norm                  normal_z;
        logic [AREA_WIDTH-1:0]  area_times_two;
        logic                   degenerate;
    } t_tri_out;

endpackage

FILE: hdl/tun_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module tun_sqrt_cell #(
    parameter int ROOT_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    input  logic [ROOT_W:0]       i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    output logic [2*ROOT_W-1:0]   o_rad,
    output logic [ROOT_W:0]       o_rem,
    output logic [ROOT_W-1:0]     o_root
);

    logic [ROOT_W+3:0]   w_acc;
    logic [ROOT_W+3:0]   w_trial;
    logic                w_take;
    logic [2*ROOT_W-1:0] n_rad, r_rad;
    logic [ROOT_W:0]     n_rem, r_rem;
    logic [ROOT_W-1:0]   n_root, r_root;

    // Try to subtract 4*root + 1 from the remainder with two new bits.
    always_comb begin
        w_acc   = {1'b0, i_rem, i_rad[2*ROOT_W-1 -: 2]};
        w_trial = w_acc - {2'b00, i_root, 2'b01};
        w_take  = !w_trial[ROOT_W+3];
        n_rem   = w_take ? w_trial[ROOT_W:0] : w_acc[ROOT_W:0];
        n_root  = {i_root[ROOT_W-2:0], w_take};
        n_rad   = {i_rad[2*ROOT_W-3:0], 2'b00};
    end

    // Stage register, held while the pipeline is frozen.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: hdl/tun_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module tun_div_cell #(
    parameter int DIV_W = 8,
    parameter int QUO_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_num,
    input  logic [DIV_W-1:0]  i_div,
    input  logic [QUO_W-1:0]  i_quo,
    output logic [DIV_W-1:0]  o_rem,
    output logic [QUO_W-1:0]  o_num,
    output logic [DIV_W-1:0]  o_div,
    output logic [QUO_W-1:0]  o_quo
);

    logic [DIV_W:0]   w_acc;
    logic [DIV_W+1:0] w_diff;
    logic             w_take;
    logic [DIV_W-1:0] n_rem, r_rem, r_div;
    logic [QUO_W-1:0] n_num, r_num, n_quo, r_quo;

    // Compare the shifted remainder against the divisor.
    always_comb begin
        w_acc  = {i_rem, i_num[QUO_W-1]};
        w_diff = {1'b0, w_acc} - {2'b00, i_div};
        w_take = !w_diff[DIV_W+1];
        n_rem  = w_take ? w_diff[DIV_W-1:0] : w_acc[DIV_W-1:0];
        n_num  = {i_num[QUO_W-2:0], 1'b0};
        n_quo  = {i_quo[QUO_W-2:0], w_take};
    end

    // Stage register, held while the pipeline is frozen.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_div <= i_div;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

FILE: hdl/tun_delay.sv
// ----------------------------------------------------------------------------
// Delay line
// Shift line that keeps side data aligned with the arithmetic cells.
// ----------------------------------------------------------------------------
module tun_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [WIDTH-1:0]  i_data,
    output logic [WIDTH-1:0]  o_data
);

    logic [WIDTH-1:0] r_line [DEPTH];

    // Advance one tap per enabled cycle.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_data = r_line[DEPTH-1];

endmodule

FILE: hdl/triangle_unit_normal_area_top.sv
// ----------------------------------------------------------------------------
// Triangle unit normal and area
// Cross product, rounded magnitude and Q1.15 unit normal of one triangle.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one triangle (three vertices) per beat.
// Output channel: o_valid / i_stall carry the unit normal, twice the area and
// a degenerate flag per beat, in input order.
// Pipeline: 55 register stages. Four front stages form edges, cross product,
// squares and their sum; then a row of 33 divider cells and 17 square root
// cells per axis forms each normal component, while a row of 35 square root
// cells forms the area; one last stage rounds and formats.
// Throughput: one triangle per cycle while o_stall is low; every cell takes
// a new beat each such cycle. When the receiver stalls, a result moves into
// a one-entry skid register and the whole row of cells freezes until that
// result is taken; o_stall is high exactly while the skid register is full.
// Reset clears all valid bits and the skid valid flag; data registers are
// not reset. With no memory, a beat is taken in the first cycle after reset.
// A triangle whose cross product is zero gives a zero normal, zero area and
// the degenerate flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_unit_normal_area_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tun_pkg::t_tri_in i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output tun_pkg::t_tri_out o_data
);

    import tun_pkg::*;

    logic w_en;

    logic [PIPE_STAGES-1:0] r_vld;

    logic signed [EDGE_WIDTH-1:0]  r_u [AXES];
    logic signed [EDGE_WIDTH-1:0]  r_v [AXES];
    logic signed [CROSS_WIDTH-1:0] r_c [AXES];
    logic [SQR_WIDTH-1:0]          r_sq [AXES];
    logic [SQR_WIDTH-1:0]          r_m2 [AXES];
    logic [AXES-1:0]               r_neg3, r_neg4;
    logic                          r_deg3, r_deg4;
    logic [SUM_WIDTH-1:0]          r_s;

    t_tri_out r_out, n_out;
    t_tri_out r_skid;
    logic     r_skid_valid;

    // The whole row advances unless a result waits in the skid register.
    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Valid bits travel with the beats.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_valid};
        end
    end

    // Stage one: edge vectors from the first vertex.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u[0] <= EDGE_WIDTH'(i_data.second_x) - EDGE_WIDTH'(i_data.first_x);
            r_u[1] <= EDGE_WIDTH'(i_data.second_y) - EDGE_WIDTH'(i_data.first_y);
            r_u[2] <= EDGE_WIDTH'(i_data.second_z) - EDGE_WIDTH'(i_data.first_z);
            r_v[0] <= EDGE_WIDTH'(i_data.third_x) - EDGE_WIDTH'(i_data.first_x);
            r_v[1] <= EDGE_WIDTH'(i_data.third_y) - EDGE_WIDTH'(i_data.first_y);
            r_v[2] <= EDGE_WIDTH'(i_data.third_z) - EDGE_WIDTH'(i_data.first_z);
        end
    end

    // Stages two to four: cross product, squared magnitudes and their sum.
    for (genvar k = 0; k < AXES; k++) begin : g_front
        localparam int A = (k + 1) % AXES;
        localparam int B = (k + 2) % AXES;
        logic signed [PROD_WIDTH-1:0] w_p1, w_p2;
        logic [MAG_WIDTH-1:0]         w_mag;

        assign w_p1  = PROD_WIDTH'(r_u[A]) * PROD_WIDTH'(r_v[B]);
        assign w_p2  = PROD_WIDTH'(r_v[A]) * PROD_WIDTH'(r_u[B]);
        assign w_mag = r_c[k][CROSS_WIDTH-1] ? MAG_WIDTH'(-r_c[k]) : MAG_WIDTH'(r_c[k]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_c[k]    <= CROSS_WIDTH'(w_p1) - CROSS_WIDTH'(w_p2);
                r_sq[k]   <= SQR_WIDTH'(w_mag) * SQR_WIDTH'(w_mag);
                r_m2[k]   <= r_sq[k];
            end
        end
    end

    // Signs, the degenerate flag and the sum of squares.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < AXES; k++) begin
                r_neg3[k] <= r_c[k][CROSS_WIDTH-1];
            end
            r_neg4 <= r_neg3;
            r_deg3 <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
            r_deg4 <= r_deg3;
            r_s    <= SUM_WIDTH'(r_sq[0]) + SUM_WIDTH'(r_sq[1]) + SUM_WIDTH'(r_sq[2]);
        end
    end

    // Area: a row of square root cells over the sum of squares.
    logic [SUM_WIDTH-1:0]  w_ar_rad  [ROOT_WIDTH+1];
    logic [ROOT_WIDTH:0]   w_ar_rem  [ROOT_WIDTH+1];
    logic [ROOT_WIDTH-1:0] w_ar_root [ROOT_WIDTH+1];

    assign w_ar_rad[0]  = r_s;
    assign w_ar_rem[0]  = '0;
    assign w_ar_root[0] = '0;

    for (genvar j = 0; j < ROOT_WIDTH; j++) begin : g_area
        tun_sqrt_cell #(.ROOT_W(ROOT_WIDTH)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_ar_rad[j]),
            .i_rem  (w_ar_rem[j]),
            .i_root (w_ar_root[j]),
            .o_rad  (w_ar_rad[j+1]),
            .o_rem  (w_ar_rem[j+1]),
            .o_root (w_ar_root[j+1])
        );
    end

    logic [2*ROOT_WIDTH:0] w_area_dly;

    tun_delay #(.WIDTH(2 * ROOT_WIDTH + 1), .DEPTH(AREA_DLY)) u_area_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data ({w_ar_rem[ROOT_WIDTH], w_ar_root[ROOT_WIDTH]}),
        .o_data (w_area_dly)
    );

    // Normal: per axis, divide c^2 * 2^32 by the sum, then take a root.
    logic [SUM_WIDTH-1:0]     w_dv_rem [AXES][QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0]     w_dv_num [AXES][QUO_WIDTH+1];
    logic [SUM_WIDTH-1:0]     w_dv_div [AXES][QUO_WIDTH+1];
    logic [QUO_WIDTH-1:0]     w_dv_quo [AXES][QUO_WIDTH+1];
    logic [2*NROOT_WIDTH-1:0] w_nr_rad [AXES][NROOT_WIDTH+1];
    logic [NROOT_WIDTH:0]     w_nr_rem [AXES][NROOT_WIDTH+1];
    logic [NROOT_WIDTH-1:0]   w_nr_root [AXES][NROOT_WIDTH+1];

    for (genvar k = 0; k < AXES; k++) begin : g_norm
        // The low 32 dividend bits are zero; only bit zero of c^2 remains.
        assign w_dv_rem[k][0] = SUM_WIDTH'(r_m2[k] >> 1);
        assign w_dv_num[k][0] = {r_m2[k][0], {(QUO_WIDTH-1){1'b0}}};
        assign w_dv_div[k][0] = r_s;
        assign w_dv_quo[k][0] = '0;

        for (genvar j = 0; j < QUO_WIDTH; j++) begin : g_div
            tun_div_cell #(.DIV_W(SUM_WIDTH), .QUO_W(QUO_WIDTH)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_rem (w_dv_rem[k][j]),
                .i_num (w_dv_num[k][j]),
                .i_div (w_dv_div[k][j]),
                .i_quo (w_dv_quo[k][j]),
                .o_rem (w_dv_rem[k][j+1]),
                .o_num (w_dv_num[k][j+1]),
                .o_div (w_dv_div[k][j+1]),
                .o_quo (w_dv_quo[k][j+1])
            );
        end

        assign w_nr_rad[k][0]  = (2 * NROOT_WIDTH)'(w_dv_quo[k][QUO_WIDTH]);
        assign w_nr_rem[k][0]  = '0;
        assign w_nr_root[k][0] = '0;

        for (genvar j = 0; j < NROOT_WIDTH; j++) begin : g_root
            tun_sqrt_cell #(.ROOT_W(NROOT_WIDTH)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rad  (w_nr_rad[k][j]),
                .i_rem  (w_nr_rem[k][j]),
                .i_root (w_nr_root[k][j]),
                .o_rad  (w_nr_rad[k][j+1]),
                .o_rem  (w_nr_rem[k][j+1]),
                .o_root (w_nr_root[k][j+1])
            );
        end
    end

    // Signs and the degenerate flag ride alongside the normal cells.
    logic [AXES:0] w_side;

    tun_delay #(.WIDTH(AXES + 1), .DEPTH(NORM_LAT)) u_side_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data ({r_deg4, r_neg4}),
        .o_data (w_side)
    );

    // Final stage: round to nearest, apply sign and saturate positive values.
    logic [NROOT_WIDTH:0]   w_half [AXES];
    logic [NROOT_WIDTH-1:0] w_q    [AXES];
    t_norm                  w_norm [AXES];
    logic [ROOT_WIDTH:0]    w_area;
    logic                   w_deg;

    always_comb begin
        w_deg = w_side[AXES];
        for (int k = 0; k < AXES; k++) begin
            w_half[k] = {1'b0, w_nr_root[k][NROOT_WIDTH]} + (NROOT_WIDTH + 1)'(1);
            w_q[k]    = w_half[k][NROOT_WIDTH:1];
            if (w_deg) begin
                w_norm[k] = '0;
            end else if (w_side[k]) begin
                w_norm[k] = NORM_WIDTH'(-w_q[k]);
            end else if (w_q[k] > NROOT_WIDTH'(NORM_MAX)) begin
                w_norm[k] = NORM_WIDTH'(NORM_MAX);
            end else begin
                w_norm[k] = NORM_WIDTH'(w_q[k]);
            end
        end
        // Round the area up when the remainder exceeds the root.
        w_area = {1'b0, w_area_dly[ROOT_WIDTH-1:0]};
        if (w_area_dly[2*ROOT_WIDTH:ROOT_WIDTH] > w_area) begin
            w_area = w_area + (ROOT_WIDTH + 1)'(1);
        end
        n_out.normal_x       = w_norm[0];
        n_out.normal_y       = w_norm[1];
        n_out.normal_z       = w_norm[2];
        n_out.area_times_two = w_deg ? '0 : AREA_WIDTH'(w_area);
        n_out.degenerate     = w_deg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    // Skid register: catches the last stage when the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_vld[PIPE_STAGES-1] && i_stall) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid <= r_out;
        end
    end

    assign o_valid = r_skid_valid || r_vld[PIPE_STAGES-1];
    assign o_data  = r_skid_valid ? r_skid : r_out;

    // All result fields are zero.
    logic w_out_zero;

    assign w_out_zero = (o_data.normal_x == '0) && (o_data.normal_y == '0) &&
                        (o_data.normal_z == '0) && (o_data.area_times_two == '0);

    // Checks on the skid path and on the result.
    `TUN_ASSERT(a_skid_drain, i_clk, i_rst_n, r_skid_valid && !i_stall |=> !r_skid_valid)
    `TUN_ASSERT(a_frozen, i_clk, i_rst_n, r_skid_valid |=> $stable(r_vld))
    `TUN_ASSERT(a_deg_zero, i_clk, i_rst_n, o_valid && o_data.degenerate |-> w_out_zero)
    `TUN_NEVER(a_area_live, i_clk, i_rst_n, o_valid && !o_data.degenerate && o_data.area_times_two == '0)

endmodule
